/* rtl/indexed_insert_remove_list_core_assert.svh */
// Assertion macros shared by the list core RTL.
// No dependencies; include inside a module body.
`ifndef INDEXED_INSERT_REMOVE_LIST_CORE_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_LIST_CORE_ASSERT_SVH

// same-cycle implication
`define IIRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("list core assertion failed");

// next-cycle implication
`define IIRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("list core assertion failed");

`endif

/* rtl/iirl_pkg.sv */
// Types and codes for the indexed insert/remove list core.
// No dependencies.
package iirl_pkg;

	localparam int POS_W = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_GET    = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [POS_W-1:0] position;
		logic [31:0]      elem_value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic [5:0]  count_after;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [POS_W-1:0] pos;
	} cell_ctl_t;

endpackage

/* rtl/iirl_cell.sv */
// One list slot: holds an element and shifts with its neighbors.
// Depends on iirl_pkg.
module iirl_cell #(
	parameter int INDEX      = 0,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                  clk,
	input  iirl_pkg::cell_ctl_t   ctl,
	input  logic [ELEM_WIDTH-1:0] ins_data,
	input  logic [ELEM_WIDTH-1:0] left_data,
	input  logic [ELEM_WIDTH-1:0] right_data,
	output logic [ELEM_WIDTH-1:0] data,
	output logic [ELEM_WIDTH-1:0] sel_data
);
	import iirl_pkg::*;

	localparam logic [POS_W-1:0] IDX = INDEX[POS_W-1:0];

	logic [ELEM_WIDTH-1:0] data_q;
	logic                  hit;
	logic                  above;

	assign hit   = (ctl.pos == IDX);
	assign above = (IDX > ctl.pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (above) begin
				data_q <= left_data;
			end else if (hit) begin
				data_q <= ins_data;
			end
		end else if (ctl.rem) begin
			// cells past the tail pick up junk, never read
			if (hit || above) begin
				data_q <= right_data;
			end
		end
	end

	assign data     = data_q;
	assign sel_data = hit ? data_q : '0;

endmodule

/* rtl/indexed_insert_remove_list_core.sv */
// Channel   Dir  Handshake           Payload
// req       in   req_valid/req_stall  iirl_pkg::req_t
// rsp       out  rsp_valid/rsp_stall  iirl_pkg::rsp_t
//
// One item per cycle unless stalled: every cell compares its index with the
// request position and shifts in the same cycle; the result is registered.
// Reset clears the count and output valid; slot contents stay undefined.
// req_stall is high in the first cycle after reset and while a result is
// held under rsp_stall. Depends on iirl_pkg and the assertion header.
module indexed_insert_remove_list_core #(
	parameter int DEPTH      = 32,
	parameter int ELEM_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  iirl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output iirl_pkg::rsp_t rsp
);
	import iirl_pkg::*;

	`include "indexed_insert_remove_list_core_assert.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = CW + POS_W;
	localparam logic [CW-1:0] FULL_CNT = DEPTH[CW-1:0];

	logic          run_q;
	logic          out_valid_q;
	rsp_t          rsp_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          accept;
	op_t           op;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] cpos_x;
	logic          is_full;
	logic          is_empty;
	logic          in_range;
	status_t       status;
	cell_ctl_t     ctl;

	logic [ELEM_WIDTH+31:0] val_ext;
	logic [ELEM_WIDTH-1:0]  ins_data;
	logic [ELEM_WIDTH-1:0]  cell_data [DEPTH];
	logic [ELEM_WIDTH-1:0]  cell_sel [DEPTH];
	logic [ELEM_WIDTH-1:0]  rd_data;
	logic [ELEM_WIDTH+31:0] rd_ext;
	logic [CW+5:0]          cnt_ext;

	assign req_stall = !run_q || (out_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign op        = op_t'(req.req_type);

	assign pos_x    = {{CW{1'b0}}, req.position};
	assign cnt_x    = {{POS_W{1'b0}}, count_q};
	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);
	assign in_range = (pos_x < cnt_x);

	assign val_ext  = {{ELEM_WIDTH{1'b0}}, req.elem_value};
	assign ins_data = val_ext[ELEM_WIDTH-1:0];

	always_comb begin
		cpos_x    = pos_x;
		ctl.ins   = 1'b0;
		ctl.rem   = 1'b0;
		status    = ST_OK;
		count_nxt = count_q;
		unique case (op)
			OP_INSERT: begin
				if (is_full) begin
					status = ST_FULL;
				end else begin
					if (pos_x > cnt_x) cpos_x = cnt_x;
					ctl.ins   = accept;
					count_nxt = count_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					if (!in_range) cpos_x = cnt_x - XW'(1);
					ctl.rem   = accept;
					count_nxt = count_q - CW'(1);
				end
			end
			OP_GET: begin
				if (!in_range) status = ST_RANGE;
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
		ctl.pos = cpos_x[POS_W-1:0];
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_d;
		logic [ELEM_WIDTH-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		iirl_cell #(
			.INDEX      (i),
			.ELEM_WIDTH (ELEM_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.ins_data   (ins_data),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.sel_data   (cell_sel[i])
		);
	end

	// at most one cell drives a nonzero selection
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_data = rd_data | cell_sel[i];
		end
		if (!(op == OP_GET && in_range)) rd_data = '0;
	end

	assign rd_ext  = {32'd0, rd_data};
	assign cnt_ext = {6'd0, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			run_q <= 1'b1;
			if (accept) begin
				out_valid_q <= 1'b1;
				count_q     <= count_nxt;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.read_value  <= rd_ext[31:0];
			rsp_q.status      <= status;
			rsp_q.count_after <= cnt_ext[5:0];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	`IIRL_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT)
	`IIRL_ASSERT_NEXT(a_insert_grows, clk, arst_n,
		accept && op == OP_INSERT && !is_full, count_q == $past(count_q) + CW'(1))
	`IIRL_ASSERT_NEXT(a_remove_shrinks, clk, arst_n,
		accept && op == OP_REMOVE && !is_empty, count_q == $past(count_q) - CW'(1))
	`IIRL_ASSERT_NOW(a_err_reads_zero, clk, arst_n,
		out_valid_q && rsp_q.status != ST_OK, rsp_q.read_value == 32'd0)
	`IIRL_ASSERT_NEXT(a_refused_keeps, clk, arst_n,
		accept && ((op == OP_INSERT && is_full) || (op == OP_REMOVE && is_empty)),
		count_q == $past(count_q))

endmodule
